>>> rtl/lrsb_pkg.sv
// Package for the byte-wise LSD radix sorter: record and port types,
// sizing constants and the key digit select.
// No dependencies.
package lrsb_pkg;

   localparam int MAX_RECORDS_DEF = 64;
   localparam int BUCKET_COUNT    = 256;
   localparam int DIGIT_PASSES    = 4;
   localparam int DIGIT_W         = $clog2(BUCKET_COUNT);
   localparam int PASS_W          = $clog2(DIGIT_PASSES);
   localparam int ID_W            = 32;
   localparam int KEY_W           = 32;
   localparam logic [DIGIT_W-1:0] DIGIT_MASK = 8'hFF;

   typedef struct packed {
      logic [ID_W-1:0]  record_id;
      logic [KEY_W-1:0] sort_key;
      logic             final_record;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]  out_id;
      logic [KEY_W-1:0] out_key;
      logic             out_last;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } rec_type;

   // select the key byte used by a pass, least significant byte first
   function automatic logic [DIGIT_W-1:0] key_digit(input logic [KEY_W-1:0] key,
                                                    input logic [PASS_W-1:0] pass);
      logic [DIGIT_W-1:0] d;
      case (pass)
         2'd0:    d = key[7:0];
         2'd1:    d = key[15:8];
         2'd2:    d = key[23:16];
         2'd3:    d = key[31:24];
         default: d = key[7:0];
      endcase
      return d & DIGIT_MASK;
   endfunction

endpackage

>>> rtl/lrsb_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Read returns the old contents on a same-cycle write. No dependencies.
module lrsb_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lsd_radix_sort_bytes.sv
// Top level of the LSD radix sorter: load sequencer, counting-sort passes
// and result emission around two record RAMs and one bucket RAM.
// Depends on lrsb_pkg and lrsb_ram.
//
//   channel  ports                    handshake
//   -------  -----------------------  ------------------------------------
//   request  start, busy, req_data    transfer when start && !busy
//   result   rsp_strobe, rsp_data     transfer on every cycle rsp_strobe=1
//
// Loading takes a record on each transfer. The record marked final raises busy
// and starts the sort; the time that sort and emission take is set by the
// bucket RAM walks (256-entry clear and prefix sweep per pass) and by the
// count and scatter read-modify-write pipeline, which takes one record per
// cycle. Reset is synchronous and active high; it clears the control state
// and empties the load store. The result side cannot stall: results stream
// one per cycle and the final strobe, marked last, shows in the same cycle
// that busy falls.
module lsd_radix_sort_bytes
   import lrsb_pkg::*;
#(
   parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_RECORDS + 1);
   localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int REC_W = $bits(rec_type);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_COUNT,
      ST_PREFIX,
      ST_SCATTER,
      ST_EMIT
   } state_type;

   // control registers
   state_type          state_ff;
   logic [CNT_W-1:0]   n_ff;        // records in the store
   logic [CNT_W-1:0]   idx_ff;      // record ordinal being issued
   logic [PASS_W-1:0]  pass_ff;
   logic [DIGIT_W-1:0] bkt_idx_ff;  // bucket sweep address
   logic               issue_ff;    // reads still being issued
   logic               s1_ff;       // first RAM read data valid
   logic               s2_ff;       // bucket read data valid
   logic               last_s1_ff;
   logic               fwd_valid_ff;
   logic               rsp_strobe_ff;

   // payload registers
   rec_type            rec_s2_ff;
   logic [DIGIT_W-1:0] dig_s2_ff;
   logic [DIGIT_W-1:0] fwd_addr_ff;
   logic [CNT_W-1:0]   fwd_data_ff;
   logic [CNT_W-1:0]   run_ff;
   logic [DIGIT_W-1:0] pf_addr_ff;
   rsp_type            rsp_data_ff;

   // RAM ports
   logic               a_wr_en, b_wr_en, bkt_wr_en;
   logic [IDX_W-1:0]   a_wr_addr, b_wr_addr, rec_rd_addr;
   rec_type            a_wr_data, b_wr_data;
   logic [REC_W-1:0]   a_rd_raw, b_rd_raw;
   rec_type            a_rd_data, b_rd_data;
   logic [DIGIT_W-1:0] bkt_wr_addr, bkt_rd_addr;
   logic [CNT_W-1:0]   bkt_wr_data, bkt_rd_data;

   // datapath
   logic               accept;
   logic               src_is_a;
   rec_type            src_rec;
   logic [CNT_W-1:0]   src_addr_full;
   logic [DIGIT_W-1:0] s1_digit;
   logic [CNT_W-1:0]   bkt_cur;
   logic [CNT_W-1:0]   bkt_new;
   logic [CNT_W-1:0]   pf_sum;
   logic               issue_end;

   assign busy      = (state_ff != ST_LOAD);
   assign accept    = start && !busy;
   assign a_rd_data = rec_type'(a_rd_raw);
   assign b_rd_data = rec_type'(b_rd_raw);

   // even passes read store A and write store B; odd passes the reverse
   assign src_is_a      = (state_ff == ST_EMIT) || !pass_ff[0];
   assign src_rec       = src_is_a ? a_rd_data : b_rd_data;
   // scatter walks the records from the end backward
   assign src_addr_full = (state_ff == ST_SCATTER) ? (n_ff - CNT_W'(1) - idx_ff) : idx_ff;
   assign rec_rd_addr   = src_addr_full[IDX_W-1:0];
   assign s1_digit      = key_digit(src_rec.key, pass_ff);
   assign issue_end     = (idx_ff == n_ff - CNT_W'(1));

   // forward the count written last cycle; the RAM read issued then saw the old value
   assign bkt_cur = (fwd_valid_ff && (fwd_addr_ff == dig_s2_ff)) ? fwd_data_ff : bkt_rd_data;
   assign bkt_new = (state_ff == ST_SCATTER) ? (bkt_cur - CNT_W'(1)) : (bkt_cur + CNT_W'(1));
   assign pf_sum  = run_ff + bkt_rd_data;

   // RAM write and read steering
   always_comb begin
      a_wr_en     = 1'b0;
      a_wr_addr   = n_ff[IDX_W-1:0];
      a_wr_data   = rec_s2_ff;
      b_wr_en     = 1'b0;
      b_wr_addr   = bkt_new[IDX_W-1:0];
      b_wr_data   = rec_s2_ff;
      bkt_wr_en   = 1'b0;
      bkt_wr_addr = dig_s2_ff;
      bkt_wr_data = bkt_new;
      bkt_rd_addr = s1_digit;
      case (state_ff)
         ST_LOAD: begin
            // drop loads once the store is full
            a_wr_en   = accept && (n_ff < CNT_W'(MAX_RECORDS));
            a_wr_data = '{id: req_data.record_id, key: req_data.sort_key};
         end
         ST_CLEAR: begin
            bkt_wr_en   = 1'b1;
            bkt_wr_addr = bkt_idx_ff;
            bkt_wr_data = '0;
         end
         ST_COUNT: begin
            bkt_wr_en = s2_ff;
         end
         ST_PREFIX: begin
            bkt_rd_addr = bkt_idx_ff;
            bkt_wr_en   = s1_ff;
            bkt_wr_addr = pf_addr_ff;
            bkt_wr_data = pf_sum;
         end
         ST_SCATTER: begin
            bkt_wr_en = s2_ff;
            if (pass_ff[0]) begin
               a_wr_en   = s2_ff;
               a_wr_addr = bkt_new[IDX_W-1:0];
            end else begin
               b_wr_en = s2_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         n_ff          <= '0;
         idx_ff        <= '0;
         pass_ff       <= '0;
         bkt_idx_ff    <= '0;
         issue_ff      <= 1'b0;
         s1_ff         <= 1'b0;
         s2_ff         <= 1'b0;
         last_s1_ff    <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         // one result per emission read, for exactly one cycle
         rsp_strobe_ff <= (state_ff == ST_EMIT) && s1_ff;
         fwd_valid_ff  <= s2_ff;
         fwd_addr_ff   <= dig_s2_ff;
         fwd_data_ff   <= bkt_new;
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (n_ff < CNT_W'(MAX_RECORDS)) begin
                     n_ff <= n_ff + CNT_W'(1);
                  end
                  if (req_data.final_record) begin
                     state_ff   <= ST_CLEAR;
                     pass_ff    <= '0;
                     bkt_idx_ff <= '0;
                  end
               end
            end
            ST_CLEAR: begin
               bkt_idx_ff <= bkt_idx_ff + DIGIT_W'(1);
               if (bkt_idx_ff == DIGIT_MASK) begin
                  state_ff <= ST_COUNT;
                  issue_ff <= 1'b1;
                  idx_ff   <= '0;
               end
            end
            ST_COUNT, ST_SCATTER: begin
               s1_ff     <= issue_ff;
               s2_ff     <= s1_ff;
               rec_s2_ff <= src_rec;
               dig_s2_ff <= s1_digit;
               if (issue_ff) begin
                  idx_ff <= idx_ff + CNT_W'(1);
                  if (issue_end) begin
                     issue_ff <= 1'b0;
                  end
               end
               // advance once the pipeline has drained
               if (!issue_ff && !s1_ff && !s2_ff) begin
                  if (state_ff == ST_COUNT) begin
                     state_ff   <= ST_PREFIX;
                     issue_ff   <= 1'b1;
                     bkt_idx_ff <= '0;
                     run_ff     <= '0;
                  end else if (pass_ff == PASS_W'(DIGIT_PASSES - 1)) begin
                     state_ff <= ST_EMIT;
                     issue_ff <= 1'b1;
                     idx_ff   <= '0;
                  end else begin
                     state_ff   <= ST_CLEAR;
                     pass_ff    <= pass_ff + PASS_W'(1);
                     bkt_idx_ff <= '0;
                  end
               end
            end
            ST_PREFIX: begin
               s1_ff      <= issue_ff;
               pf_addr_ff <= bkt_idx_ff;
               if (issue_ff) begin
                  bkt_idx_ff <= bkt_idx_ff + DIGIT_W'(1);
                  if (bkt_idx_ff == DIGIT_MASK) begin
                     issue_ff <= 1'b0;
                  end
               end
               if (s1_ff) begin
                  run_ff <= pf_sum;
               end
               if (!issue_ff && !s1_ff) begin
                  state_ff <= ST_SCATTER;
                  issue_ff <= 1'b1;
                  idx_ff   <= '0;
               end
            end
            ST_EMIT: begin
               s1_ff      <= issue_ff;
               last_s1_ff <= issue_end;
               if (issue_ff) begin
                  idx_ff <= idx_ff + CNT_W'(1);
                  if (issue_end) begin
                     issue_ff <= 1'b0;
                  end
               end
               if (s1_ff) begin
                  rsp_data_ff   <= '{out_id: a_rd_data.id, out_key: a_rd_data.key,
                                     out_last: last_s1_ff};
               end
               // drop back to loading with an empty store as the last result
               // is registered, so busy falls with its strobe
               if (s1_ff && last_s1_ff) begin
                  state_ff <= ST_LOAD;
                  n_ff     <= '0;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   lrsb_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_RECORDS),
      .ADDR_W(IDX_W)
   ) u_store_a (
      .clock  (clock),
      .wr_en  (a_wr_en),
      .wr_addr(a_wr_addr),
      .wr_data(a_wr_data),
      .rd_addr(rec_rd_addr),
      .rd_data(a_rd_raw)
   );

   lrsb_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_RECORDS),
      .ADDR_W(IDX_W)
   ) u_store_b (
      .clock  (clock),
      .wr_en  (b_wr_en),
      .wr_addr(b_wr_addr),
      .wr_data(b_wr_data),
      .rd_addr(rec_rd_addr),
      .rd_data(b_rd_raw)
   );

   lrsb_ram #(
      .WIDTH (CNT_W),
      .DEPTH (BUCKET_COUNT),
      .ADDR_W(DIGIT_W)
   ) u_buckets (
      .clock  (clock),
      .wr_en  (bkt_wr_en),
      .wr_addr(bkt_wr_addr),
      .wr_data(bkt_wr_data),
      .rd_addr(bkt_rd_addr),
      .rd_data(bkt_rd_data)
   );

endmodule

>>> rtl/lrsb_checker.sv
// Port-level checks for the radix sorter, bound to the top level.
// Depends on lrsb_pkg and lsd_radix_sort_bytes.
module lrsb_checker
   import lrsb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input req_type req_data,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // a final record starts the sort
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.final_record) |=> busy)
      else $error("final record transfer did not start the sort");

   // a plain record keeps the block loading
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_data.final_record) |=> !busy)
      else $error("non-final record transfer raised busy");

   // results other than the last come only while sorting
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.out_last) |-> busy)
      else $error("result transfer outside the sort");

   // the last result shows with the fall of busy, and busy falls only then
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.out_last) |-> (!busy && $past(busy)))
      else $error("last result not aligned with the end of busy");

   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && rsp_data.out_last))
      else $error("busy fell without the last result");

endmodule

bind lsd_radix_sort_bytes lrsb_checker u_lrsb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .req_data  (req_data),
   .busy      (busy),
   .rsp_strobe(rsp_strobe),
   .rsp_data  (rsp_data)
);

>>> tb/tb.sv
// Self-checking bench for lsd_radix_sort_bytes: loads record sets, predicts the stable
// ascending key order with a byte-wise counting sort of its own, and checks every result.
// Depends on lrsb_pkg and the RTL of the sorter.
module tb;
   import lrsb_pkg::*;

   localparam int STORE_DEPTH = MAX_RECORDS_DEF;
   // Slowest correct run: ~270 items, each a final record with a full store
   // (a full sort plus 64 results) and the longest sender gap, taken about
   // four times over.
   localparam int unsigned RUN_LIMIT   = 3_000_000;
   // One full sort; any stray result would show within this window.
   localparam int unsigned TAIL_CYCLES = 2700;
   localparam int unsigned RANDOM_ITEMS = 124;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // records loaded for the current set, in arrival order
   rec_type     load_store[$];
   // sorted records still to come out of the block
   rsp_type     sorted_out_q[$];
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;

   lsd_radix_sort_bytes i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   // Stop a hung run; the limit sits far above any correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
   endtask

   // Four counting-sort passes over the key bytes, least significant first,
   // scattering from the end backward so equal keys keep arrival order.
   function automatic void emit_sorted_set();
      rec_type     work [STORE_DEPTH];
      rec_type     scratch [STORE_DEPTH];
      int unsigned bucket [BUCKET_COUNT];
      int          n;
      logic [7:0]  digit;
      rsp_type     r;
      n = load_store.size();
      for (int i = 0; i < n; i++) work[i] = load_store[i];
      for (int p = 0; p < DIGIT_PASSES; p++) begin
         foreach (bucket[b]) bucket[b] = 0;
         for (int i = 0; i < n; i++) bucket[work[i].key[8*p +: 8]]++;
         for (int b = 1; b < BUCKET_COUNT; b++) bucket[b] += bucket[b-1];
         for (int i = n - 1; i >= 0; i--) begin
            digit = work[i].key[8*p +: 8];
            bucket[digit]--;
            scratch[bucket[digit]] = work[i];
         end
         work = scratch;
      end
      for (int i = 0; i < n; i++) begin
         r.out_id   = work[i].id;
         r.out_key  = work[i].key;
         r.out_last = (i == n - 1);
         sorted_out_q.push_back(r);
      end
      load_store.delete();
   endfunction

   // Store an accepted record; drop it when the store is full. A final
   // record always starts the sort, even when it was dropped itself.
   function automatic void absorb_record(input req_type item);
      rec_type rec;
      rec.id  = item.record_id;
      rec.key = item.sort_key;
      if (load_store.size() < STORE_DEPTH) load_store.push_back(rec);
      if (item.final_record) emit_sorted_set();
   endfunction

   // Check results first, then take the transfer of this edge, so a result
   // and a new load in the same cycle never disturb each other.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (sorted_out_q.size() == 0) begin
            report_mismatch("result with nothing expected, key", rsp_data.out_key, '0);
         end else begin
            want = sorted_out_q.pop_front();
            if (rsp_data.out_id !== want.out_id)
               report_mismatch("out_id", rsp_data.out_id, want.out_id);
            if (rsp_data.out_key !== want.out_key)
               report_mismatch("out_key", rsp_data.out_key, want.out_key);
            if (rsp_data.out_last !== want.out_last)
               report_mismatch("out_last", 32'(rsp_data.out_last), 32'(want.out_last));
         end
      end
      if (!reset && start && !busy) absorb_record(req_data);
   end

   // Mostly short gaps, a few long ones; bursts run with none at all.
   function automatic int unsigned pick_gap(input bit burst);
      int unsigned r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Keys: fully random, built from colliding byte values, or a repeat of an
   // earlier key of the set to exercise stability.
   function automatic logic [31:0] pick_key(input logic [31:0] prior[$]);
      logic [31:0] k;
      int unsigned mode;
      int unsigned lane;
      mode = $urandom_range(0, 9);
      k    = $urandom();
      if (mode >= 4 && mode < 8) begin
         for (int b = 0; b < 4; b++) begin
            lane = $urandom_range(0, 5);
            case (lane)
               0:       k[8*b +: 8] = 8'h00;
               1:       k[8*b +: 8] = 8'hFF;
               2:       k[8*b +: 8] = 8'h80;
               3:       k[8*b +: 8] = 8'h7F;
               4:       k[8*b +: 8] = 8'($urandom_range(0, 3));
               default: k[8*b +: 8] = 8'($urandom());
            endcase
         end
      end else if (mode >= 8 && prior.size() > 0) begin
         k = prior[$urandom_range(0, prior.size() - 1)];
      end
      return k;
   endfunction

   // Present one record, hold it until the transfer, then idle for the gap.
   task automatic send_record(input logic [31:0] id, input logic [31:0] key,
                              input logic is_final, input int unsigned gap);
      req_type item;
      item.record_id    = id;
      item.sort_key     = key;
      item.final_record = is_final;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and hold off until every predicted result has come out.
   task automatic hold_until_drained();
      start <= 1'b0;
      while (sorted_out_q.size() != 0) @(posedge clock);
   endtask

   // Sets of one record, with the field extremes.
   task automatic test_single_record();
      send_record(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, pick_gap(1'b0));
      send_record(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, pick_gap(1'b0));
   endtask

   // Unsigned ordering across the sign bit and the key extremes.
   task automatic test_key_extremes();
      send_record(32'h0000_0001, 32'hFFFF_FFFF, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0002, 32'h0000_0000, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0003, 32'h8000_0000, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0004, 32'h7FFF_FFFF, 1'b0, pick_gap(1'b0));
      send_record(32'hAAAA_AAAA, 32'h0000_0001, 1'b0, pick_gap(1'b0));
      send_record(32'h5555_5555, 32'hFFFF_FFFE, 1'b1, pick_gap(1'b0));
   endtask

   // Equal keys interleaved with others must keep arrival order.
   task automatic test_equal_keys_stable();
      send_record(32'h0000_0011, 32'h1234_5678, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0012, 32'h1234_5677, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0013, 32'h1234_5678, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0014, 32'h1234_5678, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0015, 32'h1234_5679, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0016, 32'h1234_5678, 1'b1, pick_gap(1'b0));
   endtask

   // Keys that differ in one byte lane only, so each pass decides alone,
   // plus a higher byte that must win over a lower one.
   task automatic test_byte_lanes();
      send_record(32'h0000_0021, 32'hFF00_0000, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0022, 32'h00FF_0000, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0023, 32'h0000_FF00, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0024, 32'h0000_00FF, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0025, 32'h0100_0000, 1'b0, pick_gap(1'b0));
      send_record(32'h0000_0026, 32'h00FF_FFFF, 1'b1, pick_gap(1'b0));
   endtask

   // Fill the store, then push extra records and a final one that all get
   // dropped; the stored set must still be sorted and sent.
   task automatic test_store_overflow();
      logic [31:0] keys[$];
      logic [31:0] k;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         k = pick_key(keys);
         keys.push_back(k);
         send_record($urandom(), k, 1'b0, pick_gap(1'b0));
      end
      repeat (3) send_record($urandom(), $urandom(), 1'b0, pick_gap(1'b0));
      send_record($urandom(), $urandom(), 1'b1, pick_gap(1'b0));
   endtask

   // Random sets: mostly small, some medium, one full-size set that fits
   // exactly; one pause for a full drain along the way.
   task automatic test_random_sets();
      logic [31:0] keys[$];
      logic [31:0] k;
      int unsigned sent;
      int unsigned set_no;
      int unsigned set_size;
      int unsigned r;
      bit          burst;
      sent   = 0;
      set_no = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (set_no == 3)  set_size = STORE_DEPTH;
         else if (r < 80)  set_size = $urandom_range(1, 8);
         else if (r < 95)  set_size = $urandom_range(9, 32);
         else              set_size = $urandom_range(33, STORE_DEPTH);
         burst = ($urandom_range(0, 3) == 0);
         keys.delete();
         for (int i = 0; i < set_size; i++) begin
            k = pick_key(keys);
            keys.push_back(k);
            send_record($urandom(), k, (i == set_size - 1), pick_gap(burst));
         end
         sent += set_size;
         if (set_no == 1) hold_until_drained();
         set_no++;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_record();
      test_key_extremes();
      test_equal_keys_stable();
      test_byte_lanes();
      test_store_overflow();
      test_random_sets();
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && sorted_out_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
